// File: hw/rtl/sfr_pkg.sv
// Shared types and constants of the streaming find-and-replace block.
package sfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int TEXT_W    = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIND_PATTERN   = 2'd0,
      CSR_FIND_LENGTH    = 2'd1,
      CSR_REPLACE_TEXT   = 2'd2,
      CSR_REPLACE_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_present;
      logic              last_of_text;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type     reg_index;
      logic [TEXT_W-1:0] write_data;
   } csr_payload_type;

   // Controls of one window cell.
   typedef struct packed {
      logic shift;
      logic active;
   } win_ctl_type;

   // Controls of one output burst cell.
   typedef struct packed {
      logic load;
      logic shift;
   } burst_ctl_type;

endpackage

// File: hw/rtl/sfr_chan_if.sv
// Valid/ready channel interface used for requests, responses and register writes.
interface sfr_chan_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
//
// Bytes arrive as requests on req_if (a byte and an end-of-text mark) and leave
// as responses on rsp_if (a byte, a present flag and a last flag). Registers are
// written through csr_if, which is always ready; writes are to be made while
// idle, which the block itself does not enforce. Each request pushes its byte
// into a shift line of window cells, newest at cell 0. The cells compare in
// parallel against the pattern, aligned so that the oldest pending byte meets
// the first pattern byte. A request yields zero or more response bytes, which
// are loaded at once into a burst line of cells and drained one byte per cycle,
// while the receiver takes them, into the response register. A request that
// yields at most one byte is taken every cycle while the receiver keeps up; one
// that yields more holds the input off while the burst line drains, since the
// burst line has room for one request's bytes at a time. When the receiver
// stalls, the response register holds its byte and the burst line keeps the
// next request's bytes, so one more request is taken. Reset clears the
// registers, the window count and both output stages.
module stream_find_replace #(
   parameter int MAX_FIND_BYTES    = 8,
   parameter int MAX_REPLACE_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   sfr_chan_if.sink   req_if,
   sfr_chan_if.source rsp_if,
   sfr_chan_if.sink   csr_if
);
   import sfr_pkg::*;

   localparam int BURST_DEPTH = (MAX_FIND_BYTES > MAX_REPLACE_BYTES) ?
                                MAX_FIND_BYTES : MAX_REPLACE_BYTES;
   localparam int CNT_W  = $clog2(MAX_FIND_BYTES + 1);
   localparam int BLEN_W = $clog2(BURST_DEPTH + 1);

   // Where the bytes of a new burst come from.
   typedef enum logic [1:0] {
      SRC_PASS,
      SRC_REPLACE,
      SRC_WINDOW,
      SRC_MARK
   } src_type;

   // Configuration registers.
   logic [TEXT_W-1:0] find_pattern_ff;
   logic [LEN_W-1:0]  find_length_ff;
   logic [TEXT_W-1:0] replace_text_ff;
   logic [LEN_W-1:0]  replace_length_ff;

   // Window state.
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [BYTE_W-1:0] win_q    [MAX_FIND_BYTES];
   logic [BYTE_W-1:0] win_next [MAX_FIND_BYTES];
   logic [BYTE_W-1:0] pat_byte [MAX_FIND_BYTES];
   logic [MAX_FIND_BYTES-1:0] hit;
   win_ctl_type       win_ctl  [MAX_FIND_BYTES];

   // Burst line state.
   logic [BYTE_W-1:0] burst_q    [BURST_DEPTH];
   logic [BYTE_W-1:0] burst_load [BURST_DEPTH];
   burst_ctl_type     burst_ctl;
   logic [BLEN_W-1:0] burst_cnt_ff;
   logic [BLEN_W-1:0] burst_cnt_in;
   logic              burst_present_ff;
   logic              burst_last_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_present_ff;
   logic              rsp_last_ff;

   // Step decode.
   logic              req_accept;
   logic              csr_write;
   logic              move;
   logic [CNT_W-1:0]  flen;
   logic [BLEN_W-1:0] rlen;
   logic [CNT_W-1:0]  cnt_plus;
   logic              full;
   logic              matched;
   logic [BLEN_W-1:0] load_len;
   src_type           load_src;
   logic              load_present;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   // The output stage moves the head of the burst whenever the response
   // register is free or is being emptied in this cycle.
   assign move = (burst_cnt_ff != '0) && (!rsp_valid_ff || rsp_if.ready);

   // A request is taken when the burst line is empty or gives up its last byte now.
   assign req_if.ready = (burst_cnt_ff == '0) ||
                         ((burst_cnt_ff == BLEN_W'(1)) && move);
   assign req_accept   = req_if.valid && req_if.ready;

   // Lengths above the supported maximum saturate.
   always_comb begin
      if (find_length_ff > LEN_W'(MAX_FIND_BYTES)) begin
         flen = CNT_W'(MAX_FIND_BYTES);
      end else begin
         flen = find_length_ff[CNT_W-1:0];
      end
      if (replace_length_ff > LEN_W'(MAX_REPLACE_BYTES)) begin
         rlen = BLEN_W'(MAX_REPLACE_BYTES);
      end else begin
         rlen = BLEN_W'(replace_length_ff);
      end
   end

   // Cell j holds the byte that arrived j requests ago, so after the push the
   // oldest pending byte sits in cell flen-1 and must equal pattern byte 0.
   always_comb begin
      for (int j = 0; j < MAX_FIND_BYTES; j++) begin
         pat_byte[j] = '0;
         for (int p = 0; p < MAX_FIND_BYTES; p++) begin
            if (CNT_W'(p) == (flen - CNT_W'(1) - CNT_W'(j))) begin
               pat_byte[j] = find_pattern_ff[BYTE_W*p +: BYTE_W];
            end
         end
         win_ctl[j].shift  = req_accept && (flen != '0);
         win_ctl[j].active = CNT_W'(j) < flen;
      end
   end

   for (genvar j = 0; j < MAX_FIND_BYTES; j++) begin : g_win
      if (j == 0) begin : g_head
         assign win_next[j] = req_if.payload.data_byte;
      end else begin : g_tail
         assign win_next[j] = win_q[j-1];
      end
      sfr_window_cell u_cell (
         .clock        (clock),
         .ctl          (win_ctl[j]),
         .shift_in     (win_next[j]),
         .pattern_byte (pat_byte[j]),
         .stored_byte  (win_q[j]),
         .hit          (hit[j])
      );
   end

   // What one request does to the window and which bytes it emits.
   always_comb begin
      cnt_plus     = cnt_ff + CNT_W'(1);
      full         = (cnt_plus == flen);
      matched      = full && (&hit);
      cnt_in       = cnt_ff;
      load_len     = '0;
      load_src     = SRC_WINDOW;
      load_present = 1'b1;
      if (req_accept) begin
         if (flen == '0) begin
            // Pass-through: the byte goes straight out.
            load_src = SRC_PASS;
            load_len = BLEN_W'(1);
         end else if (matched) begin
            load_src = SRC_REPLACE;
            load_len = rlen;
            cnt_in   = '0;
         end else begin
            // The oldest byte leaves once the window is full; at the end of
            // the text the whole window leaves, oldest first.
            load_src = SRC_WINDOW;
            cnt_in   = full ? cnt_ff : cnt_plus;
            if (req_if.payload.end_of_text) begin
               load_len = BLEN_W'(cnt_plus);
            end else if (full) begin
               load_len = BLEN_W'(1);
            end
         end
         if (req_if.payload.end_of_text) begin
            cnt_in = '0;
            // An end of text that emits nothing still sends an empty marker.
            if (load_len == '0) begin
               load_src     = SRC_MARK;
               load_len     = BLEN_W'(1);
               load_present = 1'b0;
            end
         end
      end
      // A new pattern length discards the pending window.
      if (csr_write && (csr_if.payload.reg_index == CSR_FIND_LENGTH)) begin
         cnt_in = '0;
      end
   end

   // Burst contents, head first.
   always_comb begin
      for (int k = 0; k < BURST_DEPTH; k++) begin
         burst_load[k] = '0;
         case (load_src)
            SRC_PASS: begin
               if (k == 0) begin
                  burst_load[k] = req_if.payload.data_byte;
               end
            end
            SRC_REPLACE: begin
               if (k < MAX_REPLACE_BYTES) begin
                  burst_load[k] = replace_text_ff[BYTE_W*k +: BYTE_W];
               end
            end
            SRC_WINDOW: begin
               for (int j = 0; j < MAX_FIND_BYTES; j++) begin
                  if ((int'(cnt_plus) - 1 - k) == j) begin
                     burst_load[k] = win_next[j];
                  end
               end
            end
            SRC_MARK: begin
               burst_load[k] = '0;
            end
            default: begin
               burst_load[k] = '0;
            end
         endcase
      end
   end

   assign burst_ctl.load  = req_accept && (load_len != '0);
   assign burst_ctl.shift = move;

   for (genvar k = 0; k < BURST_DEPTH; k++) begin : g_burst
      logic [BYTE_W-1:0] next_byte;
      if (k == BURST_DEPTH - 1) begin : g_end
         assign next_byte = '0;
      end else begin : g_mid
         assign next_byte = burst_q[k+1];
      end
      sfr_burst_cell u_cell (
         .clock       (clock),
         .ctl         (burst_ctl),
         .load_byte   (burst_load[k]),
         .shift_in    (next_byte),
         .stored_byte (burst_q[k])
      );
   end

   always_comb begin
      if (burst_ctl.load) begin
         burst_cnt_in = load_len;
      end else if (move) begin
         burst_cnt_in = burst_cnt_ff - BLEN_W'(1);
      end else begin
         burst_cnt_in = burst_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_pattern_ff   <= '0;
         find_length_ff    <= '0;
         replace_text_ff   <= '0;
         replace_length_ff <= '0;
         cnt_ff            <= '0;
         burst_cnt_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_if.payload.reg_index)
               CSR_FIND_PATTERN:   find_pattern_ff   <= csr_if.payload.write_data;
               CSR_FIND_LENGTH:    find_length_ff    <= csr_if.payload.write_data[LEN_W-1:0];
               CSR_REPLACE_TEXT:   replace_text_ff   <= csr_if.payload.write_data;
               CSR_REPLACE_LENGTH: replace_length_ff <= csr_if.payload.write_data[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         cnt_ff       <= cnt_in;
         burst_cnt_ff <= burst_cnt_in;
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (burst_ctl.load) begin
         burst_present_ff <= load_present;
         burst_last_ff    <= req_if.payload.end_of_text;
      end
      if (move) begin
         rsp_byte_ff    <= burst_q[0];
         rsp_present_ff <= burst_present_ff;
         rsp_last_ff    <= burst_last_ff && (burst_cnt_ff == BLEN_W'(1));
      end
   end

   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.payload.out_byte     = rsp_byte_ff;
   assign rsp_if.payload.byte_present = rsp_present_ff;
   assign rsp_if.payload.last_of_text = rsp_last_ff;

   // The window never holds a full pattern's worth of bytes between requests.
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff < flen) || ((flen == '0) && (cnt_ff == '0)))
      else $error("window count reached the pattern length");

   // The burst line never holds more than its depth.
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= BLEN_W'(BURST_DEPTH))
      else $error("burst count beyond depth");

   // A request is only taken when at most the final burst byte is left.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (burst_cnt_ff <= BLEN_W'(1)))
      else $error("request taken while burst still draining");

   // An empty marker only closes a text.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> rsp_last_ff)
      else $error("empty marker without last flag");
endmodule

// File: hw/rtl/sfr_window_cell.sv
// One cell of the pending window: holds a byte and compares its incoming byte.
module sfr_window_cell (
   input  logic                       clock,
   input  sfr_pkg::win_ctl_type       ctl,
   input  logic [sfr_pkg::BYTE_W-1:0] shift_in,
   input  logic [sfr_pkg::BYTE_W-1:0] pattern_byte,
   output logic [sfr_pkg::BYTE_W-1:0] stored_byte,
   output logic                       hit
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   always_comb begin
      byte_in = ctl.shift ? shift_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign stored_byte = byte_ff;
   // The compare looks at the value the cell takes on this shift.
   assign hit = !ctl.active || (shift_in == pattern_byte);
endmodule

// File: hw/rtl/sfr_burst_cell.sv
// One cell of the output burst line: loaded in parallel, drained toward the head.
module sfr_burst_cell (
   input  logic                       clock,
   input  sfr_pkg::burst_ctl_type     ctl,
   input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] shift_in,
   output logic [sfr_pkg::BYTE_W-1:0] stored_byte
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   always_comb begin
      if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift) begin
         byte_in = shift_in;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign stored_byte = byte_ff;
endmodule

// File: tb/sv/tb_stream_find_replace.sv
// Self-checking testbench of the streaming find-and-replace block.
module tb_stream_find_replace;
   import sfr_pkg::*;

   localparam int MAX_FIND_BYTES    = 8;
   localparam int MAX_REPLACE_BYTES = 8;
   localparam int HALF_PERIOD       = 5;
   localparam int RESET_CYCLES      = 4;
   // Room for the output registers and a full burst of eight bytes, with margin.
   localparam int SETTLE_CYCLES     = 12;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int RANDOM_PHASES     = 9;

   // Kinds of rows in the directed table.
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // Ways in which the receiver paces its ready.
   typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_COIN, RX_SPARSE} rx_mode_type;

   // One row of the directed table. A register write uses reg_index and
   // write_data; a request uses the byte fields. Where typed is set, the
   // single response of that request is given by the exp_ fields.
   typedef struct {
      row_kind_type  kind;
      csr_index_type reg_index;
      logic [63:0]   write_data;
      logic [7:0]    data_byte;
      logic          end_of_text;
      logic          typed;
      logic [7:0]    exp_byte;
      logic          exp_present;
      logic          exp_last;
   } directed_row_type;

   // One request waiting to be sent, with its typed response if it has one.
   typedef struct {
      logic [7:0]      data_byte;
      logic            end_of_text;
      logic            typed;
      rsp_payload_type fixed_rsp;
   } text_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfr_chan_if #(.payload_type(req_payload_type)) req_ch ();
   sfr_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   sfr_chan_if #(.payload_type(csr_payload_type)) csr_ch ();

   stream_find_replace #(
      .MAX_FIND_BYTES   (MAX_FIND_BYTES),
      .MAX_REPLACE_BYTES(MAX_REPLACE_BYTES)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Predictor state: its own copy of the registers and of the pending window.
   logic [63:0] pred_pattern;
   logic [3:0]  pred_find_len;
   logic [63:0] pred_replace;
   logic [3:0]  pred_replace_len;
   logic [7:0]  pred_window [MAX_FIND_BYTES];
   int unsigned pred_count;

   // Responses produced by the most recent request, and all responses still due.
   rsp_payload_type step_results [$];
   rsp_payload_type expected_bytes [$];

   text_item_type text_q [$];
   int unsigned   queued_count   = 0;
   int unsigned   accepted_count = 0;
   int unsigned   fail_count     = 0;
   bit            hold_request   = 1'b0;
   int unsigned   stream_left    = 8;

   directed_row_type directed_rows [32];

   function automatic int unsigned find_len_eff();
      return (pred_find_len > MAX_FIND_BYTES) ? MAX_FIND_BYTES : pred_find_len;
   endfunction

   function automatic int unsigned replace_len_eff();
      return (pred_replace_len > MAX_REPLACE_BYTES) ? MAX_REPLACE_BYTES : pred_replace_len;
   endfunction

   function automatic void model_clear();
      pred_pattern     = '0;
      pred_find_len    = '0;
      pred_replace     = '0;
      pred_replace_len = '0;
      foreach (pred_window[i]) pred_window[i] = '0;
      pred_count = 0;
   endfunction

   function automatic void model_write(csr_index_type idx, logic [63:0] value);
      case (idx)
         CSR_FIND_PATTERN: pred_pattern = value;
         CSR_FIND_LENGTH: begin
            // A new pattern length throws away whatever was pending.
            pred_find_len = value[3:0];
            pred_count    = 0;
         end
         CSR_REPLACE_TEXT:   pred_replace = value;
         CSR_REPLACE_LENGTH: pred_replace_len = value[3:0];
         default: ;
      endcase
   endfunction

   function automatic void add_result(logic [7:0] b, logic present);
      step_results.push_back(rsp_payload_type'{out_byte: b, byte_present: present,
                                               last_of_text: 1'b0});
   endfunction

   // Advances the predictor by one text byte and leaves its responses in
   // step_results.
   function automatic void replace_step(logic [7:0] b, logic eot);
      int unsigned flen;
      int unsigned rlen;
      bit          hit;
      rsp_payload_type tail;
      flen = find_len_eff();
      rlen = replace_len_eff();
      step_results.delete();
      if (flen == 0) begin
         add_result(b, 1'b1);
      end else begin
         if (pred_count < MAX_FIND_BYTES) begin
            pred_window[pred_count] = b;
            pred_count++;
         end
         if (pred_count >= flen) begin
            hit = 1'b1;
            for (int i = 0; i < flen; i++) begin
               if (pred_window[i] != pred_pattern[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
               for (int i = 0; i < rlen; i++) add_result(pred_replace[8*i +: 8], 1'b1);
               pred_count = 0;
            end else begin
               add_result(pred_window[0], 1'b1);
               for (int i = 1; i < MAX_FIND_BYTES; i++) pred_window[i-1] = pred_window[i];
               pred_window[MAX_FIND_BYTES-1] = '0;
               pred_count--;
            end
         end
      end
      if (eot) begin
         for (int i = 0; i < pred_count && step_results.size() < 8; i++) begin
            add_result(pred_window[i], 1'b1);
         end
         pred_count = 0;
         if (step_results.size() == 0) add_result(8'h00, 1'b0);
         tail = step_results.pop_back();
         tail.last_of_text = 1'b1;
         step_results.push_back(tail);
      end
   endfunction

   function automatic void queue_text(logic [7:0] b, logic eot, logic typed,
                                      rsp_payload_type fixed);
      text_item_type item;
      item.data_byte   = b;
      item.end_of_text = eot;
      item.typed       = typed;
      item.fixed_rsp   = fixed;
      text_q.push_back(item);
      queued_count++;
   endfunction

   // Waits until every queued request has been taken and every response has
   // come back, then gives requests that yield nothing time to leave the block.
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= csr_payload_type'{reg_index: idx, write_data: value};
      do @(posedge clock); while (!csr_ch.ready);
      model_write(idx, value);
      csr_ch.valid <= 1'b0;
   endtask

   // Picks a setting for one random phase. Some phases force the extremes.
   task automatic program_random_setting(int phase);
      logic [63:0] pattern;
      logic [3:0]  flen;
      logic [3:0]  rlen;
      int unsigned sel;
      // A small alphabet makes overlaps and partial matches frequent.
      if ($urandom_range(0, 1) == 0) begin
         for (int i = 0; i < 8; i++) pattern[8*i +: 8] = 8'h61 + $urandom_range(0, 2);
      end else begin
         pattern = {$urandom, $urandom};
      end
      sel = $urandom_range(0, 9);
      if (sel == 0)      flen = 4'd0;
      else if (sel <= 6) flen = 4'($urandom_range(1, 8));
      else if (sel == 7) flen = 4'd8;
      else if (sel == 8) flen = 4'($urandom_range(9, 15));
      else               flen = 4'($urandom_range(1, 3));
      rlen = 4'($urandom_range(0, 15));
      case (phase)
         0: begin flen = 4'd8;  rlen = 4'd0;  end
         1: begin flen = 4'd15; rlen = 4'd15; end
         2: begin flen = 4'd1;  rlen = 4'd8;  end
         default: ;
      endcase
      write_reg(CSR_FIND_PATTERN, pattern);
      write_reg(CSR_REPLACE_TEXT, {$urandom, $urandom});
      write_reg(CSR_REPLACE_LENGTH, 64'(rlen));
      // Leaving the length alone now and then keeps a half-read window alive
      // across writes of the other registers.
      if (phase < 3 || $urandom_range(0, 9) < 7) write_reg(CSR_FIND_LENGTH, 64'(flen));
   endtask

   // Queues text that is mostly built from the pattern: whole copies, broken
   // prefixes and stray pattern bytes, mixed with arbitrary bytes.
   task automatic queue_random_text(int count);
      logic [7:0]  chunk [$];
      logic [7:0]  b;
      logic        eot;
      int unsigned flen;
      int unsigned sel;
      int unsigned plen;
      for (int k = 0; k < count; k++) begin
         if (chunk.size() == 0) begin
            flen = find_len_eff();
            sel  = $urandom_range(0, 99);
            if (flen == 0 || sel < 15) begin
               chunk.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 55) begin
               for (int i = 0; i < flen; i++) chunk.push_back(pred_pattern[8*i +: 8]);
            end else if (sel < 75) begin
               plen = (flen > 1) ? $urandom_range(1, flen - 1) : 1;
               for (int i = 0; i < plen; i++) chunk.push_back(pred_pattern[8*i +: 8]);
            end else begin
               chunk.push_back(pred_pattern[8*$urandom_range(0, flen - 1) +: 8]);
            end
         end
         b = chunk.pop_front();
         stream_left--;
         eot = (stream_left == 0);
         if (eot) stream_left = $urandom_range(1, 24);
         queue_text(b, eot, 1'b0, '0);
      end
   endtask

   // Request sender. It offers requests in bursts of random length separated
   // by random gaps, and once a request is offered it holds it until taken.
   // The predictor runs at the very edge at which a request is accepted.
   initial begin
      text_item_type cur_item;
      int unsigned   burst_left;
      int unsigned   gap_left;
      burst_left     = 1;
      gap_left       = 0;
      cur_item       = '{default: '0};
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      forever begin
         @(posedge clock);
         if (reset) begin
            req_ch.valid <= 1'b0;
         end else begin
            if (req_ch.valid && req_ch.ready) begin
               replace_step(cur_item.data_byte, cur_item.end_of_text);
               if (cur_item.typed) begin
                  expected_bytes.push_back(cur_item.fixed_rsp);
               end else begin
                  foreach (step_results[i]) expected_bytes.push_back(step_results[i]);
               end
               accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
               if (gap_left > 0) begin
                  gap_left--;
                  req_ch.valid <= 1'b0;
               end else if (text_q.size() > 0) begin
                  cur_item       = text_q.pop_front();
                  req_ch.payload <= req_payload_type'{data_byte: cur_item.data_byte,
                                                      end_of_text: cur_item.end_of_text};
                  req_ch.valid   <= 1'b1;
                  burst_left--;
                  if (burst_left == 0) begin
                     // Now and then a long burst runs with no gap at all.
                     burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 5);
                  end
               end else begin
                  req_ch.valid <= 1'b0;
               end
            end
         end
      end
   end

   // Response receiver. It switches between pacing modes at random; a long hold,
   // counted here, can be asked for by the main sequence.
   initial begin
      rx_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      logic [15:0] pattern;
      logic        next_ready;
      mode         = RX_ALWAYS;
      mode_left    = 0;
      hold_left    = 0;
      pattern      = 16'hffff;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
            pattern   = 16'($urandom);
         end
         mode_left--;
         pattern = {pattern[14:0], pattern[15]};
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:  next_ready = 1'b1;
               RX_PATTERN: next_ready = pattern[0];
               RX_COIN:    next_ready = ($urandom_range(0, 1) == 1);
               default:    next_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // Response checker: every accepted response is held against the oldest
   // expectation, field by field.
   initial begin
      rsp_payload_type want;
      rsp_payload_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_bytes.size() == 0) begin
               $error("unexpected response: out_byte %02h byte_present %0b last_of_text %0b",
                      got.out_byte, got.byte_present, got.last_of_text);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                  fail_count++;
               end
               if (got.byte_present !== want.byte_present) begin
                  $error("byte_present: expected %0b, actual %0b",
                         want.byte_present, got.byte_present);
                  fail_count++;
               end
               if (got.last_of_text !== want.last_of_text) begin
                  $error("last_of_text: expected %0b, actual %0b",
                         want.last_of_text, got.last_of_text);
                  fail_count++;
               end
            end
         end
      end
   end

   // Main sequence: reset, the directed table, then random phases, each with
   // a fresh setting written while the block is idle.
   initial begin
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      model_clear();

      // The first rows run with the reset setting, where every byte passes
      // straight through. Then a two-byte pattern with a three-byte
      // replacement covers a match, a failed start that slides the window,
      // a match on the final byte and a flush at the end. An empty
      // replacement on the final byte leaves only the empty end marker.
      // Oversized lengths saturate to eight bytes. Finally a byte is left
      // pending, the pattern is rewritten (the window stays) and then the
      // pattern length is rewritten, which must throw that byte away.
      directed_rows = '{
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'ha5, 1'b1, 1'b1, 8'ha5, 1'b1, 1'b1},
         '{ROW_CSR,  CSR_FIND_PATTERN,   64'h4241, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_FIND_LENGTH,    64'd2,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_REPLACE_TEXT,   64'h5a5958, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'd3,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h42, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h42, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h41, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h42, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
         '{ROW_CSR,  CSR_FIND_LENGTH,    64'd15, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_FIND_PATTERN,   64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0,
           8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_REPLACE_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_REPLACE_TEXT,   64'h0123_4567_89ab_cdef, 8'h00, 1'b0, 1'b0,
           8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'hff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
         '{ROW_ITEM, CSR_FIND_PATTERN,   64'h0,  8'h11, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_FIND_PATTERN,   64'h22, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
         '{ROW_CSR,  CSR_FIND_LENGTH,    64'd1,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].write_data);
         end else begin
            queue_text(directed_rows[i].data_byte, directed_rows[i].end_of_text,
                       directed_rows[i].typed,
                       rsp_payload_type'{out_byte:     directed_rows[i].exp_byte,
                                         byte_present: directed_rows[i].exp_present,
                                         last_of_text: directed_rows[i].exp_last});
         end
      end
      // The byte that matches the one-byte pattern, closing the stream.
      queue_text(8'h22, 1'b1, 1'b0, '0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         program_random_setting(phase);
         // Two phases hold the receiver off for a long stretch while the
         // sender keeps offering, so the block fills and stalls its input.
         if (phase == 2 || phase == 6) begin
            hold_request = 1'b1;
            queue_random_text(30);
         end else begin
            queue_random_text(15);
         end
      end

      wait_idle();
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
